[hw/rtl/wdsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdsp_pkg
// Shared constants and types of the winner-take-all disparity sub-pixel core.
// ----------------------------------------------------------------------------
package wdsp_pkg;

  localparam int MAX_RANGE_DEF = 256;
  localparam int FRAC_BITS_DEF = 4;

  localparam int COST_W     = 16;
  localparam int DISP_W     = 14;
  localparam int MIN_W      = 9;
  localparam int MAX_W      = 10;
  localparam int BASE_W     = 11;
  localparam int QDEPTH     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISP = 1'd1;

  typedef struct packed {
    logic signed [MIN_W-1:0] min_disp;
    logic signed [MAX_W-1:0] max_disp;
  } cfg_t;

  // one finished pixel, handed from the tracker to the refinement stage
  typedef struct packed {
    logic                     ok;
    logic [COST_W-1:0]        c1;
    logic [COST_W-1:0]        c2;
    logic [COST_W-1:0]        low;
    logic signed [BASE_W-1:0] base;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[hw/rtl/wdsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdsp_if
// Valid/ready channels: cost beats in, refined disparity beats out.
// ----------------------------------------------------------------------------
interface wdsp_cost_if;
  import wdsp_pkg::*;
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;
  modport source (output valid, output cost, input ready);
  modport sink   (input valid, input cost, output ready);
endinterface

interface wdsp_res_if;
  import wdsp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DISP_W-1:0] disparity_fixed;
  logic                     valid_res;
  modport source (output valid, output disparity_fixed, output valid_res, input ready);
  modport sink   (input valid, input disparity_fixed, input valid_res, output ready);
endinterface

[hw/rtl/wdsp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdsp_front
// Per-pixel cost tracker: minimum, maximum and neighbour costs; pushes a job
// into the queue with the last cost of each pixel.
// ----------------------------------------------------------------------------
module wdsp_front #(
  parameter int MAX_RANGE = wdsp_pkg::MAX_RANGE_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  wdsp_pkg::cfg_t  cfg,
  wdsp_cost_if.sink       in_chan,
  input  wdsp_pkg::qstat_t qstat,
  output logic            push,
  output wdsp_pkg::job_t  job
);
  import wdsp_pkg::*;

  localparam int POS_W = $clog2(MAX_RANGE);
  localparam logic signed [11:0] RMAX = 12'(MAX_RANGE);

  logic [POS_W-1:0]  pos_r, pos_nxt, best_r, best_nxt, last;
  logic [COST_W-1:0] low_r, low_nxt, high_r, high_nxt, prev_r;
  logic [COST_W-1:0] before_r, before_nxt, after_r, after_nxt;
  logic              await_r, await_nxt;
  logic [POS_W-1:0]  cur_best;
  logic [COST_W-1:0] cur_low, cur_high, cur_prev, cur_before, cur_after;
  logic              cur_await, first, is_last, acc;
  logic signed [11:0] rng;
  logic [COST_W-1:0] cost;

  assign cost          = in_chan.cost;
  assign in_chan.ready = !qstat.full;
  assign acc           = in_chan.valid && in_chan.ready;

  always_comb begin
    rng = {{2{cfg.max_disp[MAX_W-1]}}, cfg.max_disp}
        - {{3{cfg.min_disp[MIN_W-1]}}, cfg.min_disp};
    priority if (rng < 12'sd1) begin
      last = '0;
    end else if (rng > RMAX) begin
      last = POS_W'(MAX_RANGE - 1);
    end else begin
      last = POS_W'(rng - 12'sd1);
    end
  end

  always_comb begin
    first      = (pos_r == '0);
    cur_low    = first ? '1 : low_r;
    cur_high   = first ? '0 : high_r;
    cur_best   = first ? '0 : best_r;
    cur_prev   = first ? '0 : prev_r;
    cur_before = first ? '0 : before_r;
    cur_after  = first ? '0 : after_r;
    cur_await  = first ? 1'b0 : await_r;

    after_nxt  = cur_await ? cost : cur_after;
    await_nxt  = 1'b0;
    low_nxt    = cur_low;
    best_nxt   = cur_best;
    before_nxt = cur_before;
    if (cost < cur_low) begin
      low_nxt    = cost;
      best_nxt   = pos_r;
      before_nxt = cur_prev;
      await_nxt  = 1'b1;
    end
    high_nxt = (cost > cur_high) ? cost : cur_high;
    is_last  = (pos_r >= last);
    pos_nxt  = is_last ? '0 : pos_r + 1'b1;
  end

  always_comb begin
    push     = acc && is_last;
    job.ok   = !((high_nxt == low_nxt) || (best_nxt == '0) || (best_nxt >= last));
    job.c1   = before_nxt;
    job.c2   = after_nxt;
    job.low  = low_nxt;
    job.base = {{2{cfg.min_disp[MIN_W-1]}}, cfg.min_disp} + BASE_W'(best_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      low_r    <= '1;
      high_r   <= '0;
      best_r   <= '0;
      prev_r   <= '0;
      before_r <= '0;
      after_r  <= '0;
      await_r  <= 1'b0;
    end else if (acc) begin
      pos_r    <= pos_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      best_r   <= best_nxt;
      prev_r   <= cost;
      before_r <= before_nxt;
      after_r  <= after_nxt;
      await_r  <= await_nxt;
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_RANGE - 1))
    else $error("position beyond range");
`endif

endmodule

[hw/rtl/wdsp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdsp_queue
// Small job queue between the cost tracker and the refinement stage.
// ----------------------------------------------------------------------------
module wdsp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wdsp_pkg::job_t   job_in,
  input  logic             pop,
  output wdsp_pkg::job_t   job_out,
  output wdsp_pkg::qstat_t qstat
);
  import wdsp_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign qstat.full  = (count_r == CNT_W'(QDEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign job_out     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full))
    else $error("job pushed into full queue");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count lost a pop");
`endif

endmodule

[hw/rtl/wdsp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdsp_back
// Parabolic refinement: restoring divider one quotient bit per cycle,
// rounding, offset and saturation into the result register.
// ----------------------------------------------------------------------------
module wdsp_back #(
  parameter int FRAC_BITS = wdsp_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wdsp_pkg::job_t   job,
  input  wdsp_pkg::qstat_t qstat,
  output logic             pop,
  wdsp_res_if.source       out_chan
);
  import wdsp_pkg::*;

  localparam int DW    = 18 + FRAC_BITS;
  localparam int DVW   = 18;
  localparam int CNT_W = $clog2(DW + 1);
  localparam int VW    = DW + 2;
  localparam logic signed [VW-1:0] SAT_HI = VW'(2 ** (DISP_W - 1) - 1);
  localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]               st_r;
  logic [DW-1:0]            quo_r;
  logic [DVW-1:0]           rem_r, dvs_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     neg_r, vres_r;
  logic signed [BASE_W-1:0] base_r;
  logic signed [DISP_W-1:0] disp_r;

  logic signed [18:0] dsum;
  logic [16:0]        den;
  logic [COST_W-1:0]  diff;
  logic [DW-1:0]      dividend;
  logic [DVW:0]       rem_sh, rem_sub;
  logic               qbit;
  logic signed [VW-1:0] qs, base_x, val;

  assign pop = (st_r == ST_IDLE) && !qstat.empty;

  always_comb begin
    dsum = 19'(job.c1) + 19'(job.c2) - 19'({job.low, 1'b0});
    den  = (dsum < 19'sd1) ? 17'd1 : 17'(dsum);
    diff = (job.c1 >= job.c2) ? job.c1 - job.c2 : job.c2 - job.c1;
    dividend = (DW'(diff) << FRAC_BITS) + DW'(den);
  end

  always_comb begin
    rem_sh  = {rem_r, quo_r[DW-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    qbit    = (rem_sh >= {1'b0, dvs_r});
  end

  always_comb begin
    qs     = neg_r ? -VW'(quo_r) : VW'(quo_r);
    base_x = VW'(base_r);
    val    = (base_x <<< FRAC_BITS) + qs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      unique case (st_r)
        ST_IDLE: if (pop) st_r <= job.ok ? ST_DIV : ST_DONE;
        ST_DIV:  if (cnt_r == CNT_W'(DW - 1)) st_r <= ST_FIN;
        ST_FIN:  st_r <= ST_DONE;
        ST_DONE: if (out_chan.ready) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        if (pop) begin
          quo_r  <= dividend;
          rem_r  <= '0;
          dvs_r  <= {den, 1'b0};
          cnt_r  <= '0;
          neg_r  <= (job.c1 < job.c2);
          base_r <= job.base;
          disp_r <= '0;
          vres_r <= 1'b0;
        end
      end
      ST_DIV: begin
        rem_r <= qbit ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
        quo_r <= {quo_r[DW-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_FIN: begin
        priority if (val > SAT_HI) begin
          disp_r <= DISP_W'(SAT_HI);
        end else if (val < SAT_LO) begin
          disp_r <= DISP_W'(SAT_LO);
        end else begin
          disp_r <= DISP_W'(val);
        end
        vres_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_chan.valid           = (st_r == ST_DONE);
  assign out_chan.disparity_fixed = disp_r;
  assign out_chan.valid_res       = vres_r;

`ifndef SYNTH
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.valid_res) |-> (out_chan.disparity_fixed == '0))
    else $error("invalid result carries a nonzero disparity");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> (cnt_r < CNT_W'(DW)))
    else $error("divider step count overrun");
`endif

endmodule

[hw/rtl/wta_disparity_subpixel_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wta_disparity_subpixel_core
// Winner-take-all disparity pick with parabolic sub-pixel refinement.
//
// in_chan carries one cost beat per disparity of a pixel, from the lower
// bound up to one below the upper bound (range clipped to 1..MAX_RANGE).
// With the last beat of a pixel the tracker hands a job to a four-entry
// queue; out_chan then delivers one beat: disparity_fixed with FRAC_BITS
// fraction bits and valid_res (0 for flat costs or a minimum at either end
// of the range). Costs are taken one per cycle while the queue has room.
// A valid result passes through the refinement stage in order: pop, a
// restoring divider of 18 + FRAC_BITS quotient bits at one bit per cycle,
// saturation and the result beat; an invalid one goes from pop straight
// to the result beat. Short pixels fill the queue and stall in_chan. A
// stalled out_chan holds its result; the tracker keeps accepting until
// the queue is full. cfg_we writes register cfg_index (0 lower bound, 1
// upper bound) at the clock edge; write only while the block is idle.
// Synchronous reset empties the queue, restarts the pixel and sets the
// range to 0..63.
// ----------------------------------------------------------------------------
module wta_disparity_subpixel_core #(
  parameter int MAX_RANGE = wdsp_pkg::MAX_RANGE_DEF,
  parameter int FRAC_BITS = wdsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wdsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wdsp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  wdsp_cost_if.sink                           in_chan,
  wdsp_res_if.source                          out_chan
);
  import wdsp_pkg::*;

  cfg_t   cfg_r;
  job_t   job_in, job_out;
  qstat_t qstat;
  logic   push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_disp <= 9'sd0;
      cfg_r.max_disp <= 10'sd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_DISP: cfg_r.min_disp <= cfg_wdata[MIN_W-1:0];
        REG_MAX_DISP: cfg_r.max_disp <= cfg_wdata[MAX_W-1:0];
        default: ;
      endcase
    end
  end

  wdsp_front #(.MAX_RANGE(MAX_RANGE)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_chan (in_chan),
    .qstat   (qstat),
    .push    (push),
    .job     (job_in)
  );

  wdsp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (job_in),
    .pop     (pop),
    .job_out (job_out),
    .qstat   (qstat)
  );

  wdsp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job_out),
    .qstat    (qstat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
